@@ design/int64_alu_with_div_pow_core_assert.svh @@
// assertion macros for the int64 alu checker
`ifndef INT64_ALU_WITH_DIV_POW_CORE_ASSERT_SVH
`define INT64_ALU_WITH_DIV_POW_CORE_ASSERT_SVH

// implication checked on every clock edge outside reset
`define I64A_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// implication whose consequent is checked on the next clock edge
`define I64A_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ design/i64a_pkg.sv @@
// ----------------------------------------------------------------------------
// i64a_pkg
// shared widths, operation codes, error codes and controller commands
// ----------------------------------------------------------------------------
package i64a_pkg;

  localparam int DATA_W = 64;
  localparam int OP_W   = 4;
  localparam int ERR_W  = 2;
  localparam int CNT_W  = 7;

  localparam logic [OP_W-1:0] OP_ADD = 4'd0;
  localparam logic [OP_W-1:0] OP_SUB = 4'd1;
  localparam logic [OP_W-1:0] OP_MUL = 4'd2;
  localparam logic [OP_W-1:0] OP_DIV = 4'd3;
  localparam logic [OP_W-1:0] OP_MOD = 4'd4;
  localparam logic [OP_W-1:0] OP_POW = 4'd5;
  localparam logic [OP_W-1:0] OP_NEG = 4'd6;
  localparam logic [OP_W-1:0] OP_EQ  = 4'd7;
  localparam logic [OP_W-1:0] OP_LT  = 4'd8;
  localparam logic [OP_W-1:0] OP_LE  = 4'd9;

  localparam logic [ERR_W-1:0] ERR_NONE = 2'd0;
  localparam logic [ERR_W-1:0] ERR_DIV0 = 2'd1;
  localparam logic [ERR_W-1:0] ERR_NEXP = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic load;     // capture operands
    logic div_step; // one restoring division step
    logic mul_step; // one partial product step (acc*base)
    logic sq_step;  // one partial product step (base*base)
    logic mul_clr;  // clear partial product accumulator
    logic mul_done_acc; // write product into acc
    logic mul_done_sq;  // write product into base, shift exponent
    logic finish;   // build result into output register
  } i64a_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            exp_zero;
    logic            exp_lsb;
  } i64a_sts_t;

endpackage

@@ design/i64a_datapath.sv @@
// ----------------------------------------------------------------------------
// i64a_datapath
// operand registers, shared 16x64 partial product multiplier, divider
// ----------------------------------------------------------------------------
module i64a_datapath #(
  parameter int DataW = i64a_pkg::DATA_W
) (
  input  logic                    clk,
  input  logic [i64a_pkg::OP_W-1:0] op_i,
  input  logic [DataW-1:0]        a_i,
  input  logic [DataW-1:0]        b_i,
  input  i64a_pkg::i64a_cmd_t     cmd_i,
  input  logic [1:0]              part_i,
  output i64a_pkg::i64a_sts_t     sts_o,
  output logic [DataW-1:0]        value_o,
  output logic [i64a_pkg::ERR_W-1:0] err_o
);
  import i64a_pkg::*;

  localparam int PartW = DataW / 4;

  logic [OP_W-1:0]  op_r;
  logic [DataW-1:0] a_r, b_r;
  logic [DataW-1:0] acc_r, base_r, expo_r;
  logic [DataW-1:0] prod_r;
  logic [DataW-1:0] quo_r, rem_r, dvs_r;
  logic [DataW-1:0] value_r, value_nxt;
  logic [ERR_W-1:0] err_r, err_nxt;

  logic [DataW-1:0]   mul_src;
  logic [PartW-1:0]   mul_part;
  logic [DataW-1:0]   pp;
  logic [DataW:0]     rem_sh;
  logic [DataW:0]     rem_sub;
  logic               a_neg, b_neg;

  assign a_neg = a_r[DataW-1];
  assign b_neg = b_r[DataW-1];

  // shared multiplier: 64 x 16 slice, shifted into place
  always_comb begin
    mul_src  = cmd_i.sq_step ? base_r : acc_r;
    mul_part = base_r[part_i*PartW +: PartW];
    pp       = (mul_src * {{(DataW-PartW){1'b0}}, mul_part}) << (part_i * PartW);
  end

  assign rem_sh  = {rem_r, quo_r[DataW-1]};
  assign rem_sub = rem_sh - {1'b0, dvs_r};

  // result selection
  always_comb begin
    value_nxt = '0;
    err_nxt   = ERR_NONE;
    case (op_r)
      OP_ADD: value_nxt = a_r + b_r;
      OP_SUB: value_nxt = a_r - b_r;
      OP_MUL: value_nxt = acc_r;
      OP_DIV, OP_MOD: begin
        if (b_r == '0) err_nxt = ERR_DIV0;
        else if (op_r == OP_DIV) value_nxt = (a_neg != b_neg) ? (~quo_r + 1'b1) : quo_r;
        else value_nxt = a_neg ? (~rem_r + 1'b1) : rem_r;
      end
      OP_POW: begin
        if (b_neg) err_nxt = ERR_NEXP;
        else value_nxt = acc_r;
      end
      OP_NEG: value_nxt = ~a_r + 1'b1;
      OP_EQ:  value_nxt = {{(DataW-1){1'b0}}, a_r == b_r};
      OP_LT:  value_nxt = {{(DataW-1){1'b0}}, $signed(a_r) < $signed(b_r)};
      OP_LE:  value_nxt = {{(DataW-1){1'b0}}, !($signed(b_r) < $signed(a_r))};
      default: value_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd_i.load) begin
      op_r   <= op_i;
      a_r    <= a_i;
      b_r    <= b_i;
      acc_r  <= (op_i == OP_MUL) ? a_i : {{(DataW-1){1'b0}}, 1'b1};
      base_r <= (op_i == OP_MUL) ? b_i : a_i;
      expo_r <= b_i;
      quo_r  <= a_i[DataW-1] ? (~a_i + 1'b1) : a_i;
      dvs_r  <= b_i[DataW-1] ? (~b_i + 1'b1) : b_i;
      rem_r  <= '0;
    end
    if (cmd_i.mul_clr) prod_r <= '0;
    else if (cmd_i.mul_step || cmd_i.sq_step) prod_r <= prod_r + pp;
    if (cmd_i.mul_done_acc) acc_r <= prod_r;
    if (cmd_i.mul_done_sq) begin
      base_r <= prod_r;
      expo_r <= expo_r >> 1;
    end
    if (cmd_i.div_step) begin
      if (!rem_sub[DataW]) begin
        rem_r <= rem_sub[DataW-1:0];
        quo_r <= {quo_r[DataW-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh[DataW-1:0];
        quo_r <= {quo_r[DataW-2:0], 1'b0};
      end
    end
    if (cmd_i.finish) begin
      value_r <= value_nxt;
      err_r   <= err_nxt;
    end
  end

  assign sts_o.op       = op_r;
  assign sts_o.exp_zero = (expo_r == '0) || expo_r[DataW-1];
  assign sts_o.exp_lsb  = expo_r[0];
  assign value_o        = value_r;
  assign err_o          = err_r;
endmodule

@@ design/i64a_ctrl.sv @@
// ----------------------------------------------------------------------------
// i64a_ctrl
// sequencer for division steps, multiply slices and power iterations
// ----------------------------------------------------------------------------
module i64a_ctrl #(
  parameter int DataW = i64a_pkg::DATA_W
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_fire_i,
  input  logic [i64a_pkg::OP_W-1:0] in_op_i,
  input  logic                out_free_i,
  input  i64a_pkg::i64a_sts_t sts_i,
  output i64a_pkg::i64a_cmd_t cmd_o,
  output logic [1:0]          part_o,
  output logic                busy_o,
  output logic                res_valid_o
);
  import i64a_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_DIV, S_POW_CHK, S_MUL, S_FIN, S_OUT
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [1:0]       part_r, part_nxt;
  logic             sq_r, sq_nxt;   // current product pass squares base
  logic             single_r, single_nxt; // plain mul: one pass only
  logic             res_valid_r, res_valid_nxt;

  always_comb begin
    state_nxt = state_r; cnt_nxt = cnt_r; part_nxt = part_r;
    sq_nxt = sq_r; single_nxt = single_r; res_valid_nxt = res_valid_r;
    cmd_o = '0;
    if (out_free_i) res_valid_nxt = 1'b0;
    case (state_r)
      S_IDLE: if (in_fire_i) begin
        cmd_o.load = 1'b1;
        cnt_nxt = '0;
        if (in_op_i == OP_DIV || in_op_i == OP_MOD) state_nxt = S_DIV;
        else if (in_op_i == OP_POW) begin
          single_nxt = 1'b0; state_nxt = S_POW_CHK;
        end else if (in_op_i == OP_MUL) begin
          single_nxt = 1'b1; sq_nxt = 1'b0; part_nxt = '0;
          state_nxt = S_MUL;
        end else state_nxt = S_FIN;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DataW-1)) state_nxt = S_FIN;
      end
      S_POW_CHK: begin
        if (sts_i.exp_zero) state_nxt = S_FIN;
        else begin
          sq_nxt = !sts_i.exp_lsb; part_nxt = '0;
          cmd_o.mul_clr = 1'b1;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        if (part_r == 2'd0 && single_r && cnt_r == '0) begin
          cmd_o.mul_clr = 1'b1; cnt_nxt = CNT_W'(1);
        end else begin
          cmd_o.mul_step = !sq_r;
          cmd_o.sq_step  = sq_r;
          part_nxt = part_r + 1'b1;
          if (part_r == 2'd3) state_nxt = S_FIN;
        end
        if (part_r == 2'd3 && !(single_r && cnt_r == '0)) begin
          if (single_r) state_nxt = S_FIN;
          else state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (single_r && sts_i.op == OP_MUL && cnt_r != '0 && !sq_r) begin
          cmd_o.mul_done_acc = 1'b1; single_nxt = 1'b0; cnt_nxt = '0;
          state_nxt = S_FIN;
        end else if (sts_i.op == OP_POW && !single_r && part_r == 2'd0
                     && cnt_r == CNT_W'(1)) begin
          // product pass finished
          if (sq_r) cmd_o.mul_done_sq = 1'b1;
          else cmd_o.mul_done_acc = 1'b1;
          sq_nxt = 1'b1; cnt_nxt = '0;
          state_nxt = sq_r ? S_POW_CHK : S_POW_CHK;
          if (!sq_r) begin
            sq_nxt = 1'b1; cmd_o.mul_clr = 1'b1; state_nxt = S_MUL;
            cnt_nxt = '0;
          end
        end else if (!res_valid_r || out_free_i) begin
          cmd_o.finish = 1'b1; res_valid_nxt = 1'b1; state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    // pow product passes mark completion via cnt
    if (state_r == S_MUL && part_r == 2'd3 && sts_i.op == OP_POW) cnt_nxt = CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; cnt_r <= '0; part_r <= '0;
      sq_r <= 1'b0; single_r <= 1'b0; res_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt; cnt_r <= cnt_nxt; part_r <= part_nxt;
      sq_r <= sq_nxt; single_r <= single_nxt; res_valid_r <= res_valid_nxt;
    end
  end

  assign part_o      = part_r;
  assign busy_o      = (state_r != S_IDLE);
  assign res_valid_o = res_valid_r;
endmodule

@@ design/int64_alu_with_div_pow_core.sv @@
// ----------------------------------------------------------------------------
// int64_alu_with_div_pow_core
// signed 64-bit alu with division, remainder and power
// ----------------------------------------------------------------------------
// usage:
//   in_* is a stream slave: one beat carries operation (tuser) and the two
//   operands (tdata). out_* is a stream master: one beat per input beat with
//   the value in tdata[63:0] and error code in tdata[65:64].
//   add/sub/neg/compare and unused codes go from the accepting edge straight
//   to the finish state; mul runs four 64x16 partial product slices on one
//   shared multiplier; div/mod runs one restoring step per bit; pow finishes
//   at once for a zero or negative exponent, else runs a squaring pass per
//   exponent bit and a multiply pass per set bit (at most 63 set bits).
//   one item is in flight at a time; the next beat is taken the cycle after
//   the result is loaded. a stalled receiver only holds the finished result
//   while the next item already computes; that item's result waits for the
//   first. reset (rst_n low, synchronous) returns the sequencer to idle and
//   drops any pending result.
// ----------------------------------------------------------------------------
module int64_alu_with_div_pow_core #(
  parameter int DataW = i64a_pkg::DATA_W
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [2*DataW-1:0] in_tdata,  // operand_a, operand_b
  input  logic [3:0]        in_tuser,  // operation
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [DataW+7:0]  out_tdata  // value, error_code, zero pad
);
  import i64a_pkg::*;

  i64a_cmd_t        cmd;
  i64a_sts_t        sts;
  logic [1:0]       part;
  logic             busy, res_valid;
  logic [DataW-1:0] value;
  logic [ERR_W-1:0] err;
  logic             in_fire;

  assign in_tready = !busy;
  assign in_fire   = in_tvalid && in_tready;

  i64a_ctrl #(.DataW(DataW)) u_ctrl (
    .clk, .rst_n,
    .in_fire_i   (in_fire),
    .in_op_i     (in_tuser),
    .out_free_i  (out_tready),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .part_o      (part),
    .busy_o      (busy),
    .res_valid_o (res_valid)
  );

  i64a_datapath #(.DataW(DataW)) u_dp (
    .clk,
    .op_i    (in_tuser),
    .a_i     (in_tdata[DataW-1:0]),
    .b_i     (in_tdata[2*DataW-1:DataW]),
    .cmd_i   (cmd),
    .part_i  (part),
    .sts_o   (sts),
    .value_o (value),
    .err_o   (err)
  );

  assign out_tvalid = res_valid;
  assign out_tdata  = {6'd0, err, value};
endmodule

@@ design/i64a_checker.sv @@
// ----------------------------------------------------------------------------
// i64a_checker
// port level checks for the int64 alu
// ----------------------------------------------------------------------------
`include "int64_alu_with_div_pow_core_assert.svh"
module i64a_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [71:0]  out_tdata
);
  `I64A_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `I64A_ASSERT_IMP(a_err_range, out_tvalid, out_tdata[65:64] != 2'd3)
  `I64A_ASSERT_IMP(a_pad_zero, out_tvalid, out_tdata[71:66] == 6'd0)
  `I64A_ASSERT_NXT(a_busy_after_take, in_tvalid && in_tready, !in_tready)
endmodule

bind int64_alu_with_div_pow_core i64a_checker u_i64a_checker (
  .clk, .rst_n, .in_tvalid, .in_tready, .out_tvalid, .out_tready, .out_tdata
);
